// ----- sv/pac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and centroid package
// Shared widths, the edge word passed from front to back, the divider
// request and the back-end state type.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned PROD_W     = 2 * COORD_BITS;
  localparam int unsigned CROSS_E_W  = PROD_W + 1;
  localparam int unsigned SUM_W      = COORD_BITS + 1;
  localparam int unsigned WPROD_W    = CROSS_E_W + SUM_W;
  localparam int unsigned CROSS_W    = 48;
  localparam int unsigned WSUM_W     = 64;
  localparam int unsigned AREA_W     = 46;
  localparam int unsigned DEN_W      = 50;
  localparam int unsigned DIV_STEPS  = WSUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CROSS_W-1:0] AREA_MAX = CROSS_W'({AREA_W{1'b1}});

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         last;
  } pac_edge_t;

  typedef struct packed {
    logic [WSUM_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic              den_neg;
  } pac_div_req_t;

  typedef enum logic [1:0] {
    BK_ACCUM,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_e;

endpackage

// ----- sv/pac_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge queue
// A short first-word-fall-through queue of edge words between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module pac_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pac_pkg::pac_edge_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pac_pkg::pac_edge_t pop_data_o
);
  import pac_pkg::*;

  pac_edge_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    do_push, do_pop;

  assign full_o     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/pac_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex front end
// Accepts vertex words, tracks the first and previous vertex of the open
// ring and turns each vertex into the edge words it closes.
// ----------------------------------------------------------------------------
module pac_front #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_y_i,
  input  logic                                  last_in_ring_i,
  input  logic                                  last_in_set_i,
  output logic                                  push_o,
  output pac_pkg::pac_edge_t                    push_data_o,
  input  logic                                  full_i
);
  import pac_pkg::*;

  logic signed [COORD_BITS-1:0] x, y;
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                         open_q, pend_q;
  pac_edge_t                    pend_edge_q;
  logic                         accept, close;

  assign x = COORD_BITS'($signed(vertex_x_i[COORD_WIDTH-1:0]));
  assign y = COORD_BITS'($signed(vertex_y_i[COORD_WIDTH-1:0]));

  assign in_ready_o = !pend_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign close      = last_in_ring_i || last_in_set_i;

  always_comb begin
    push_o      = 1'b0;
    push_data_o = pend_edge_q;
    if (pend_q) begin
      push_o = !full_i;
    end else if (accept) begin
      if (open_q) begin
        push_o      = 1'b1;
        push_data_o = '{ax: prev_x_q, ay: prev_y_q, bx: x, by: y, last: 1'b0};
      end else if (close) begin
        push_o      = 1'b1;
        push_data_o = '{ax: x, ay: y, bx: x, by: y, last: last_in_set_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (pend_q) begin
      if (!full_i) begin
        pend_q <= 1'b0;
      end
    end else if (accept) begin
      open_q <= !close;
      pend_q <= open_q && close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q <= x;
      prev_y_q <= y;
      if (!open_q) begin
        first_x_q <= x;
        first_y_q <= y;
      end
      pend_edge_q <= '{ax: x, ay: y, bx: first_x_q, by: first_y_q,
                       last: last_in_set_i};
    end
  end

endmodule

// ----- sv/pac_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial centroid divider
// Restoring division of a signed weighted sum by three times the doubled
// area, one quotient bit per cycle, truncated toward zero and saturated to
// the coordinate range.
// ----------------------------------------------------------------------------
module pac_div #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  pac_pkg::pac_div_req_t                 req_i,
  output logic                                  done_o,
  output logic signed [pac_pkg::COORD_BITS-1:0] quot_o
);
  import pac_pkg::*;

  localparam logic [WSUM_W-1:0] LimPos = WSUM_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [WSUM_W-1:0] LimNeg = WSUM_W'(64'd1 << (COORD_WIDTH - 1));

  logic [WSUM_W-1:0]    acc_q, num_mag, q_sat;
  logic [DEN_W-1:0]     rem_q, den_q, rem_d;
  logic [DEN_W:0]       trial;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q, neg_q, qbit;

  assign num_mag = req_i.num[WSUM_W-1] ? (~req_i.num + WSUM_W'(1)) : req_i.num;
  assign trial   = {rem_q, acc_q[WSUM_W-1]};
  assign qbit    = (trial >= {1'b0, den_q});
  assign rem_d   = qbit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);

  always_comb begin
    if (neg_q) begin
      q_sat = (acc_q > LimNeg) ? LimNeg : acc_q;
      q_sat = ~q_sat + WSUM_W'(1);
    end else begin
      q_sat = (acc_q > LimPos) ? LimPos : acc_q;
    end
  end

  assign quot_o = COORD_BITS'(q_sat);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_mag;
      rem_q <= '0;
      den_q <= req_i.den;
      neg_q <= req_i.num[WSUM_W-1] ^ req_i.den_neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      acc_q <= {acc_q[WSUM_W-2:0], qbit};
    end
  end

endmodule

// ----- sv/pac_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulating back end
// Pipelined shoelace cross products and weighted sums, then the set-end area,
// two centroid divisions (if enabled, area nonzero) and the held result word.
// ----------------------------------------------------------------------------
module pac_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  compute_center_i,
  input  logic                                  edge_valid_i,
  input  pac_pkg::pac_edge_t                    edge_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pac_pkg::AREA_W-1:0]            twice_area_o,
  output logic signed [pac_pkg::COORD_BITS-1:0] centroid_x_o,
  output logic signed [pac_pkg::COORD_BITS-1:0] centroid_y_o,
  output logic                                  zero_area_o
);
  import pac_pkg::*;

  back_state_e state_q, state_d;

  logic                        v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic                        hold_q, fin_q;
  logic signed [PROD_W-1:0]    pab_q, pba_q;
  logic signed [SUM_W-1:0]     sx1_q, sy1_q, sx2_q, sy2_q;
  logic signed [CROSS_E_W-1:0] c2_q, c3_q;
  logic signed [WPROD_W-1:0]   wx3_q, wy3_q;
  logic signed [CROSS_W-1:0]   cross_q;
  logic signed [WSUM_W-1:0]    wsx_q, wsy_q;

  logic                        cs_neg, is_zero, start, load_area, load_cent, clear_acc;
  logic [CROSS_W-1:0]          mag;
  logic [DEN_W-1:0]            den;
  pac_div_req_t                req_x, req_y;
  logic                        done_x, done_y;
  logic signed [COORD_BITS-1:0] quot_x, quot_y;

  assign pop_o = edge_valid_i && (state_q == BK_ACCUM) && !hold_q;

  assign cs_neg  = cross_q[CROSS_W-1];
  assign mag     = cs_neg ? (~cross_q + CROSS_W'(1)) : cross_q;
  assign is_zero = (mag == '0);
  assign den     = DEN_W'(mag) + (DEN_W'(mag) << 1);
  assign req_x   = '{num: wsx_q, den: den, den_neg: cs_neg};
  assign req_y   = '{num: wsy_q, den: den, den_neg: cs_neg};

  always_comb begin
    state_d   = state_q;
    start     = 1'b0;
    load_area = 1'b0;
    load_cent = 1'b0;
    clear_acc = 1'b0;
    unique case (state_q)
      BK_ACCUM: begin
        if (fin_q) begin
          load_area = 1'b1;
          clear_acc = 1'b1;
          if (is_zero || !compute_center_i) begin
            state_d = BK_OUTPUT;
          end else begin
            start   = 1'b1;
            state_d = BK_DIVIDE;
          end
        end
      end
      BK_DIVIDE: begin
        if (done_x) begin
          load_cent = 1'b1;
          state_d   = BK_OUTPUT;
        end
      end
      BK_OUTPUT: begin
        if (out_ready_i) begin
          state_d = BK_ACCUM;
        end
      end
      default: state_d = BK_ACCUM;
    endcase
  end

  assign out_valid_o = (state_q == BK_OUTPUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_ACCUM;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      l1_q    <= 1'b0;
      l2_q    <= 1'b0;
      l3_q    <= 1'b0;
      hold_q  <= 1'b0;
      fin_q   <= 1'b0;
      cross_q <= '0;
      wsx_q   <= '0;
      wsy_q   <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= pop_o;
      l1_q    <= pop_o && edge_i.last;
      v2_q    <= v1_q;
      l2_q    <= l1_q;
      v3_q    <= v2_q;
      l3_q    <= l2_q;
      if (pop_o && edge_i.last) begin
        hold_q <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        hold_q <= 1'b0;
      end
      if (v3_q && l3_q) begin
        fin_q <= 1'b1;
      end else if (clear_acc) begin
        fin_q <= 1'b0;
      end
      if (clear_acc) begin
        cross_q <= '0;
        wsx_q   <= '0;
        wsy_q   <= '0;
      end else if (v3_q) begin
        cross_q <= cross_q + CROSS_W'(c3_q);
        wsx_q   <= wsx_q + WSUM_W'(wx3_q);
        wsy_q   <= wsy_q + WSUM_W'(wy3_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pab_q <= edge_i.ax * edge_i.by;
    pba_q <= edge_i.ay * edge_i.bx;
    sx1_q <= SUM_W'(edge_i.ax) + SUM_W'(edge_i.bx);
    sy1_q <= SUM_W'(edge_i.ay) + SUM_W'(edge_i.by);
    c2_q  <= CROSS_E_W'(pab_q) - CROSS_E_W'(pba_q);
    sx2_q <= sx1_q;
    sy2_q <= sy1_q;
    c3_q  <= c2_q;
    wx3_q <= c2_q * sx2_q;
    wy3_q <= c2_q * sy2_q;
    if (load_area) begin
      twice_area_o <= (mag > AREA_MAX) ? AREA_MAX[AREA_W-1:0] : mag[AREA_W-1:0];
      zero_area_o  <= is_zero;
      centroid_x_o <= '0;
      centroid_y_o <= '0;
    end else if (load_cent) begin
      centroid_x_o <= quot_x;
      centroid_y_o <= quot_y;
    end
  end

  pac_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req_x),
    .done_o (done_x),
    .quot_o (quot_x)
  );

  pac_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req_y),
    .done_o (done_y),
    .quot_o (quot_y)
  );

`ifndef SYNTHESIS
  a_drained_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIVIDE) |-> !(v1_q || v2_q || v3_q))
    else $error("edge in flight during division");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("centroid dividers out of step");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x |-> (state_q == BK_DIVIDE))
    else $error("divider finished outside division");

  a_fin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> hold_q)
    else $error("set end seen without the queue held");
`endif

endmodule

// ----- sv/polygon_area_centroid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and centroid
// Shoelace twice-area and centroid of a set of closed integer polygon rings.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while the queue has room; a vertex that
// closes a ring of more than one vertex holds the front end until it has
// pushed both its incoming edge and the closing edge. Edge words wait in a
// four-word queue and pass through a three-stage multiply pipeline into the
// accumulators. On the vertex that ends a set, the back end drains the
// pipeline and then, when the centroid is enabled and the area is not zero,
// runs two serial dividers side by side; the result is held in an output
// register until taken. Meanwhile edge words of the next set fill the queue.
// Results are unscaled clipper units.
module polygon_area_centroid #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_y_i,
  input  logic                                  last_in_ring_i,
  input  logic                                  last_in_set_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pac_pkg::AREA_W-1:0]            twice_area_o,
  output logic signed [pac_pkg::COORD_BITS-1:0] centroid_x_o,
  output logic signed [pac_pkg::COORD_BITS-1:0] centroid_y_o,
  output logic                                  zero_area_o
);
  import pac_pkg::*;

  logic      compute_center_q;
  logic      push, full, pop, edge_valid;
  pac_edge_t push_data, edge_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compute_center_q <= 1'b1;
    end else if (cfg_we_i) begin
      compute_center_q <= cfg_wdata_i;
    end
  end

  pac_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_in_ring_i(last_in_ring_i),
    .last_in_set_i (last_in_set_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  pac_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (edge_valid),
    .pop_data_o (edge_word)
  );

  pac_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .compute_center_i(compute_center_q),
    .edge_valid_i    (edge_valid),
    .edge_i          (edge_word),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .twice_area_o    (twice_area_o),
    .centroid_x_o    (centroid_x_o),
    .centroid_y_o    (centroid_y_o),
    .zero_area_o     (zero_area_o)
  );

endmodule

// ----- dv/polygon_area_centroid_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and centroid testbench
// Streams rings of vertices into the block: a few hand-picked sets, one long
// set of full-range squares with a large area, then random sets under all
// settings of the centroid enable. A tracker predicts each result word from
// the accepted vertices and checks the words that come out.
// ----------------------------------------------------------------------------
module polygon_area_centroid_tb;
  import pac_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [AREA_W-1:0]            twice_area;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic                         zero_area;
  } shape_t;

  class shoelace_tracker;
    localparam longint unsigned NEG_LIMIT = 64'd1 << (COORD_BITS - 1);
    localparam longint unsigned POS_LIMIT = NEG_LIMIT - 1;

    coord_t             first_x, first_y, prev_x, prev_y;
    bit                 ring_open;
    logic [CROSS_W-1:0] cross_acc;
    logic [WSUM_W-1:0]  moment_x, moment_y;
    bit                 centre_on;
    shape_t             pending_shapes[$];
    int unsigned        shapes_seen;
    int unsigned        mismatches;

    function new();
      first_x     = '0;
      first_y     = '0;
      prev_x      = '0;
      prev_y      = '0;
      ring_open   = 1'b0;
      cross_acc   = '0;
      moment_x    = '0;
      moment_y    = '0;
      centre_on   = 1'b1;
      shapes_seen = 0;
      mismatches  = 0;
    endfunction

    function void add_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      longint cprod, sum_x, sum_y;
      cprod     = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
      sum_x     = longint'(ax) + longint'(bx);
      sum_y     = longint'(ay) + longint'(by);
      cross_acc = cross_acc + cprod[CROSS_W-1:0];
      moment_x  = moment_x + cprod * sum_x;
      moment_y  = moment_y + cprod * sum_y;
    endfunction

    // Truncated quotient, saturated to the signed coordinate range.
    function coord_t centre_coord(logic [WSUM_W-1:0] num, logic [WSUM_W-1:0] den,
                                  bit den_neg);
      logic [WSUM_W-1:0] num_mag, quot;
      bit                negative;
      negative = num[WSUM_W-1] ^ den_neg;
      num_mag  = num[WSUM_W-1] ? -num : num;
      quot     = num_mag / den;
      if (negative) begin
        if (quot > NEG_LIMIT) quot = NEG_LIMIT;
        quot = -quot;
      end else if (quot > POS_LIMIT) begin
        quot = POS_LIMIT;
      end
      return quot[COORD_BITS-1:0];
    endfunction

    function void take_vertex(coord_t x, coord_t y, bit end_ring, bit end_set);
      shape_t             shape;
      logic [CROSS_W-1:0] area_mag;
      logic [WSUM_W-1:0]  den;
      if (!ring_open) begin
        first_x   = x;
        first_y   = y;
        ring_open = 1'b1;
      end else begin
        add_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      if (end_ring || end_set) begin
        add_edge(x, y, first_x, first_y);
        ring_open = 1'b0;
      end
      if (end_set) begin
        area_mag         = cross_acc[CROSS_W-1] ? -cross_acc : cross_acc;
        shape.twice_area = (area_mag > AREA_MAX) ? AREA_MAX[AREA_W-1:0]
                                                 : area_mag[AREA_W-1:0];
        shape.zero_area  = (area_mag == '0);
        shape.centre_x   = '0;
        shape.centre_y   = '0;
        if (!shape.zero_area && centre_on) begin
          den            = WSUM_W'(area_mag) * 3;
          shape.centre_x = centre_coord(moment_x, den, cross_acc[CROSS_W-1]);
          shape.centre_y = centre_coord(moment_y, den, cross_acc[CROSS_W-1]);
        end
        pending_shapes = {pending_shapes, shape};
        cross_acc = '0;
        moment_x  = '0;
        moment_y  = '0;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_shape(shape_t got);
      shape_t want;
      if (pending_shapes.size() == 0) begin
        report_mismatch($sformatf("result word with no set ended, area %0d",
                                  got.twice_area));
        return;
      end
      want = pending_shapes.pop_front();
      shapes_seen++;
      if (got.twice_area !== want.twice_area)
        report_mismatch($sformatf("twice_area %0d, predicted %0d",
                                  got.twice_area, want.twice_area));
      if (got.centre_x !== want.centre_x)
        report_mismatch($sformatf("centroid_x %0d, predicted %0d",
                                  got.centre_x, want.centre_x));
      if (got.centre_y !== want.centre_y)
        report_mismatch($sformatf("centroid_y %0d, predicted %0d",
                                  got.centre_y, want.centre_y));
      if (got.zero_area !== want.zero_area)
        report_mismatch($sformatf("zero_area %0b, predicted %0b",
                                  got.zero_area, want.zero_area));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic                  cfg_wdata_i    = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  coord_t                vertex_x_i     = '0;
  coord_t                vertex_y_i     = '0;
  logic                  last_in_ring_i = 1'b0;
  logic                  last_in_set_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [AREA_W-1:0]     twice_area_o;
  coord_t                centroid_x_o;
  coord_t                centroid_y_o;
  logic                  zero_area_o;

  shoelace_tracker book;
  int unsigned     items_sent;
  bit              send_burst;
  bit              recv_burst;
  bit              held_long;

  polygon_area_centroid i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .last_in_ring_i (last_in_ring_i),
    .last_in_set_i  (last_in_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .twice_area_o   (twice_area_o),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .zero_area_o    (zero_area_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_vertex(coord_t x, coord_t y, bit end_ring, bit end_set);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vertex_x_i     <= x;
    vertex_y_i     <= y;
    last_in_ring_i <= end_ring;
    last_in_set_i  <= end_set;
    do @(posedge clk_i); while (!in_ready_o);
    book.take_vertex(x, y, end_ring, end_set);
    items_sent++;
  endtask

  // The register is only written once every result word has been taken.
  task automatic set_centre_mode(bit enable);
    in_valid_i <= 1'b0;
    while (book.pending_shapes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    book.centre_on  = enable;
  endtask

  function automatic coord_t draw_coord(int unsigned style, coord_t base);
    coord_t value;
    case (style)
      0: value = coord_t'($urandom());
      1: value = base + coord_t'($urandom_range(0, 128)) - 16'sd64;
      2: value = base + coord_t'($urandom_range(0, 4096)) - 16'sd2048;
      default: begin
        case ($urandom_range(0, 6))
          0: value = -16'sd32768;
          1: value = -16'sd32767;
          2: value = -16'sd1;
          3: value = 16'sd0;
          4: value = 16'sd1;
          5: value = 16'sd32766;
          default: value = 16'sd32767;
        endcase
      end
    endcase
    return value;
  endfunction

  // Mostly well-formed sets of closed rings; a tenth carry random ring and
  // set ends, and some sets end inside an open ring.
  task automatic send_random_set();
    int unsigned rings, verts, style;
    coord_t      base_x, base_y;
    bit          noisy, end_ring, end_set;
    rings  = $urandom_range(1, 3);
    style  = $urandom_range(0, 3);
    noisy  = ($urandom_range(0, 9) == 0);
    base_x = coord_t'($urandom());
    base_y = coord_t'($urandom());
    for (int r = 0; r < rings; r++) begin
      verts = $urandom_range(1, 7);
      for (int v = 0; v < verts; v++) begin
        end_ring = (v == verts - 1);
        end_set  = (r == rings - 1) && (v == verts - 1);
        if (end_set && $urandom_range(0, 3) == 0) end_ring = 1'b0;
        if (noisy) begin
          end_ring = ($urandom_range(0, 2) == 0);
          end_set  = end_set || ($urandom_range(0, 15) == 0);
        end
        push_vertex(draw_coord(style, base_x), draw_coord(style, base_y),
                    end_ring, end_set);
      end
    end
  endtask

  initial begin
    shape_t      got;
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 10);
      // One long stall so that the block backs up and stops taking vertices.
      if (!held_long && book.shapes_seen >= 12) begin
        held_long = 1'b1;
        hold      = 400;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.twice_area = twice_area_o;
      got.centre_x   = centroid_x_o;
      got.centre_y   = centroid_y_o;
      got.zero_area  = zero_area_o;
      book.check_shape(got);
    end
  end

  initial begin
    int unsigned drain_cycles;
    book = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_centre_mode(1'b1);

    // Small triangle whose centroid x is truncated.
    push_vertex(16'sd0, 16'sd0, 1'b0, 1'b0);
    push_vertex(16'sd4, 16'sd0, 1'b0, 1'b0);
    push_vertex(16'sd0, 16'sd3, 1'b1, 1'b1);
    // Full-range square wound clockwise, so the signed area is negative.
    push_vertex(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    push_vertex(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
    push_vertex(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    push_vertex(16'sd32767, -16'sd32768, 1'b1, 1'b1);
    // A ring of one vertex has no area.
    push_vertex(16'sd5, -16'sd7, 1'b1, 1'b1);
    // Two opposed squares cancel; a tiny triangle, closed by the set end,
    // leaves almost no area so both centroid coordinates saturate.
    push_vertex(16'sd1, -16'sd32767, 1'b0, 1'b0);
    push_vertex(16'sd32767, -16'sd32767, 1'b0, 1'b0);
    push_vertex(16'sd32767, -16'sd1, 1'b0, 1'b0);
    push_vertex(16'sd1, -16'sd1, 1'b1, 1'b0);
    push_vertex(-16'sd32767, 16'sd1, 1'b0, 1'b0);
    push_vertex(-16'sd32767, 16'sd32767, 1'b0, 1'b0);
    push_vertex(-16'sd1, 16'sd32767, 1'b0, 1'b0);
    push_vertex(-16'sd1, 16'sd1, 1'b1, 1'b0);
    push_vertex(16'sd0, 16'sd0, 1'b0, 1'b0);
    push_vertex(16'sd1, 16'sd0, 1'b0, 1'b0);
    push_vertex(16'sd0, 16'sd1, 1'b0, 1'b1);

    // A long set of full-range squares with a large summed area.
    for (int i = 0; i < 40; i++) begin
      push_vertex(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
      push_vertex(16'sd32767, -16'sd32768, 1'b0, 1'b0);
      push_vertex(16'sd32767, 16'sd32767, 1'b0, 1'b0);
      push_vertex(-16'sd32768, 16'sd32767, 1'b1, i == 39);
    end

    while (items_sent < 350) send_random_set();
    set_centre_mode(1'b0);
    while (items_sent < 600) send_random_set();
    set_centre_mode(1'b1);
    while (items_sent < 850) send_random_set();

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (book.pending_shapes.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (100) @(posedge clk_i);
    if (book.pending_shapes.size() != 0)
      book.report_mismatch($sformatf("%0d result words never arrived",
                                     book.pending_shapes.size()));
    if (book.mismatches == 0) begin
      $display("polygon_area_centroid_tb: clean");
    end else begin
      $display("polygon_area_centroid_tb: errors");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("polygon_area_centroid_tb: errors");
    $finish;
  end

endmodule
